>>> rtl/rvw_pkg.sv
package rvw_pkg;

  localparam int unsigned PosW   = 24;  // Q16.8 origin
  localparam int unsigned DirW   = 16;  // Q1.14 direction
  localparam int unsigned DistW  = 16;  // Q8.8 distance
  localparam int unsigned CoordW = 16;  // reported voxel coordinate
  // Internal voxel counters: a walk never leaves the origin voxel by more than
  // about 513 voxels per axis, so two extra bits cover every reachable voxel.
  localparam int unsigned VoxW   = 18;
  localparam int unsigned NumW   = 27;  // signed face offset in Q.8
  localparam int unsigned QuoW   = 16;  // divider quotient
  localparam int unsigned RemW   = 17;  // divider remainder
  localparam int unsigned CandW  = 17;  // saturated crossing distance

  localparam logic [1:0] KIND_QUERY   = 2'd0;
  localparam logic [1:0] KIND_HIT     = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  localparam logic [DistW-1:0] REACH_RESET = 16'd1280;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic            start;
    logic [RemW-1:0] num_hi;   // offset shifted right by two, below divisor
    logic [1:0]      num_lo;   // two low offset bits
    logic [DirW-1:0] divisor;  // magnitude of the direction component
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/rvw_if.sv
interface rvw_req_if import rvw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [PosW-1:0]  origin_x;
  logic signed [PosW-1:0]  origin_y;
  logic signed [PosW-1:0]  origin_z;
  logic signed [DirW-1:0]  dir_x;
  logic signed [DirW-1:0]  dir_y;
  logic signed [DirW-1:0]  dir_z;
  logic                    find_empty;
  logic                    voxel_solid;

  modport source (output valid, operation, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, find_empty, voxel_solid, input ready);
  modport sink (input valid, operation, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, find_empty, voxel_solid, output ready);
endinterface

interface rvw_res_if import rvw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [CoordW-1:0] voxel_x;
  logic signed [CoordW-1:0] voxel_y;
  logic signed [CoordW-1:0] voxel_z;

  modport source (output valid, kind, voxel_x, voxel_y, voxel_z, input ready);
  modport sink (input valid, kind, voxel_x, voxel_y, voxel_z, output ready);
endinterface

>>> rtl/rvw_div.sv
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QuoW bits (the high part is below the divisor).
module rvw_div import rvw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [RemW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [DirW-1:0] div_q;
  logic [1:0]      nb_q;
  logic [3:0]      cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [RemW:0]   trial;
  logic            ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, nb_q[1]};
    ge    = trial >= {2'b00, div_q};
    if (ge) begin
      rem_d = RemW'(trial - {2'b00, div_q});
    end else begin
      rem_d = trial[RemW-1:0];
    end
    quo_d = {quo_q[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num_hi;
      nb_q  <= req_i.num_lo;
      div_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      nb_q  <= {nb_q[0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

>>> rtl/voxel_ray_walker.sv
// Voxel ray walker. A start item (operation 0) loads a ray and returns the
// first voxel it enters as a query (kind 0), or kind 2 when no face
// crossing lies within reach_limit. Each answer item (operation 1) either ends
// the walk with kind 1 (the solid voxel, or the last empty one when
// find_empty was set) or returns the next query, or kind 2 as above. An answer
// while no walk is active is dropped without a result. The block takes one
// item at a time: a step runs one shared restoring divider once for each axis
// with a nonzero direction whose crossing does not saturate, then decides and
// emits; answers that end the walk go straight to the emit state. Reported
// coordinates wrap modulo 2^16.
module voxel_ray_walker import rvw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             reach_limit_we_i,
  input  logic [DistW-1:0] reach_limit_i,
  rvw_req_if.sink          req_i,
  rvw_res_if.source        res_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]              state_q;
  logic [1:0]              axis_q;
  logic [DistW-1:0]        reach_q;
  logic                    walking_q;
  logic                    empty_mode_q;
  logic signed [PosW-1:0]  org_q  [3];
  logic signed [DirW-1:0]  dir_q  [3];
  logic signed [VoxW-1:0]  vox_q  [3];
  logic signed [VoxW-1:0]  last_q [3];
  logic                    best_vld_q;
  logic [1:0]              best_axis_q;
  logic [CandW-1:0]        best_t_q;
  logic [1:0]              rkind_q;
  logic signed [VoxW-1:0]  rvox_q [3];
  logic                    ovalid_q;
  logic [1:0]              okind_q;
  logic signed [CoordW-1:0] ovox_q [3];

  logic                    accept;
  logic signed [DirW-1:0]  cur_d;
  logic signed [VoxW-1:0]  bound;
  logic signed [NumW-1:0]  offs;
  logic [NumW-1:0]         num;
  logic [DirW-1:0]         dmag;
  logic                    sat;
  logic [CandW-1:0]        cand;
  logic                    take;
  div_req_t                dreq;
  div_rsp_t                drsp;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Face offset and divisor for the axis under work.
  always_comb begin
    cur_d = dir_q[axis_q];
    bound = (cur_d > 0) ? vox_q[axis_q] + VoxW'(1) : vox_q[axis_q];
    offs  = {bound[VoxW-1], bound, 8'd0} - NumW'(org_q[axis_q]);
    num   = offs[NumW-1] ? NumW'(-offs) : NumW'(offs);
    dmag  = cur_d[DirW-1] ? DirW'(-cur_d) : DirW'(cur_d);
    // Quotient of at least 65536 is beyond any reach, so it saturates.
    sat   = num >= NumW'({dmag, 2'b00});
    cand  = (state_q == S_DIV) ? {1'b0, drsp.quot} : {1'b1, 16'd0};
    take  = !best_vld_q || (cand < best_t_q);
    dreq.start   = (state_q == S_SETUP) && (cur_d != 0) && !sat;
    dreq.num_hi  = num[RemW+1:2];
    dreq.num_lo  = num[1:0];
    dreq.divisor = dmag;
  end

  rvw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Sequencer and walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= '0;
      reach_q      <= REACH_RESET;
      walking_q    <= 1'b0;
      empty_mode_q <= 1'b0;
      best_vld_q   <= 1'b0;
      best_axis_q  <= '0;
      best_t_q     <= '0;
      rkind_q      <= KIND_QUERY;
      ovalid_q     <= 1'b0;
      okind_q      <= KIND_QUERY;
      for (int i = 0; i < 3; i++) begin
        org_q[i]  <= '0;
        dir_q[i]  <= '0;
        vox_q[i]  <= '0;
        last_q[i] <= '0;
        rvox_q[i] <= '0;
        ovox_q[i] <= '0;
      end
    end else begin
      if (reach_limit_we_i) begin
        reach_q <= reach_limit_i;
      end
      // The emit state sets the output register itself.
      if (ovalid_q && res_o.ready && state_q != S_EMIT) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            axis_q     <= '0;
            best_vld_q <= 1'b0;
            if (req_i.operation == OP_START) begin
              org_q[0] <= req_i.origin_x;
              org_q[1] <= req_i.origin_y;
              org_q[2] <= req_i.origin_z;
              dir_q[0] <= req_i.dir_x;
              dir_q[1] <= req_i.dir_y;
              dir_q[2] <= req_i.dir_z;
              vox_q[0]  <= VoxW'($signed(req_i.origin_x[PosW-1:8]));
              vox_q[1]  <= VoxW'($signed(req_i.origin_y[PosW-1:8]));
              vox_q[2]  <= VoxW'($signed(req_i.origin_z[PosW-1:8]));
              last_q[0] <= VoxW'($signed(req_i.origin_x[PosW-1:8]));
              last_q[1] <= VoxW'($signed(req_i.origin_y[PosW-1:8]));
              last_q[2] <= VoxW'($signed(req_i.origin_z[PosW-1:8]));
              empty_mode_q <= req_i.find_empty;
              walking_q    <= 1'b1;
              state_q      <= S_SETUP;
            end else if (walking_q) begin
              if (req_i.voxel_solid) begin
                walking_q <= 1'b0;
                rkind_q   <= KIND_HIT;
                for (int i = 0; i < 3; i++) begin
                  rvox_q[i] <= empty_mode_q ? last_q[i] : vox_q[i];
                end
                state_q <= S_EMIT;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  last_q[i] <= vox_q[i];
                end
                state_q <= S_SETUP;
              end
            end
          end
        end
        S_SETUP: begin
          if (dreq.start) begin
            state_q <= S_DIV;
          end else begin
            if (cur_d != 0 && take) begin
              best_vld_q  <= 1'b1;
              best_axis_q <= axis_q;
              best_t_q    <= cand;
            end
            if (axis_q == 2'd2) begin
              state_q <= S_DECIDE;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (take) begin
              best_vld_q  <= 1'b1;
              best_axis_q <= axis_q;
              best_t_q    <= cand;
            end
            if (axis_q == 2'd2) begin
              state_q <= S_DECIDE;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_SETUP;
            end
          end
        end
        S_DECIDE: begin
          if (!best_vld_q || best_t_q > {1'b0, reach_q}) begin
            walking_q <= 1'b0;
            rkind_q   <= KIND_NOTHING;
            for (int i = 0; i < 3; i++) begin
              rvox_q[i] <= '0;
            end
          end else begin
            rkind_q <= KIND_QUERY;
            for (int i = 0; i < 3; i++) begin
              if (best_axis_q == 2'(i)) begin
                vox_q[i]  <= (dir_q[i] > 0) ? vox_q[i] + VoxW'(1) : vox_q[i] - VoxW'(1);
                rvox_q[i] <= (dir_q[i] > 0) ? vox_q[i] + VoxW'(1) : vox_q[i] - VoxW'(1);
              end else begin
                rvox_q[i] <= vox_q[i];
              end
            end
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // Hold the result until the output register is free.
          if (!ovalid_q || res_o.ready) begin
            ovalid_q <= 1'b1;
            okind_q  <= rkind_q;
            for (int i = 0; i < 3; i++) begin
              ovox_q[i] <= rvox_q[i][CoordW-1:0];
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid   = ovalid_q;
  assign res_o.kind    = okind_q;
  assign res_o.voxel_x = ovox_q[0];
  assign res_o.voxel_y = ovox_q[1];
  assign res_o.voxel_z = ovox_q[2];

endmodule

>>> bench/voxel_ray_walker_test.sv
module voxel_ray_walker_test;
  import rvw_pkg::*;

  typedef struct packed {
    logic                   operation;
    logic signed [PosW-1:0] org_x;
    logic signed [PosW-1:0] org_y;
    logic signed [PosW-1:0] org_z;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
    logic                   find_empty;
    logic                   solid;
  } ray_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CoordW-1:0] vx;
    logic [CoordW-1:0] vy;
    logic [CoordW-1:0] vz;
  } walk_res_t;

  localparam int DrainCycles = 64;
  localparam int HoldCycles  = 400;

  logic clk_i;
  logic rst_ni;
  logic reach_we;
  logic [DistW-1:0] reach_val;

  rvw_req_if req ();
  rvw_res_if res ();

  voxel_ray_walker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .reach_limit_we_i(reach_we),
    .reach_limit_i   (reach_val),
    .req_i           (req),
    .res_o           (res)
  );

  // Own copy of the walker state.
  longint         ray_org [3];
  longint         ray_dir [3];
  longint         cur_vox [3];
  longint         empty_vox [3];
  bit             empty_mode;
  bit             walking;
  logic [DistW-1:0] reach;

  walk_res_t expected_walk[$];
  int        idle_pct;
  int        stall_pct;
  int        hold_left;
  int        fail_count;
  int        item_count;
  int        result_count;
  int        hit_count;
  int        nothing_count;

  // Clock.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Next face crossing: returns a query, or nothing when no crossing is within reach.
  function automatic walk_res_t next_crossing();
    longint    t;
    longint    best_t;
    longint    num;
    longint    bnd;
    longint    d;
    int        best;
    walk_res_t r;
    best = -1;
    best_t = 0;
    for (int a = 0; a < 3; a++) begin
      d = ray_dir[a];
      if (d != 0) begin
        bnd = (d > 0) ? cur_vox[a] + 1 : cur_vox[a];
        num = bnd * 256 - ray_org[a];
        if (num < 0) num = -num;
        if (d < 0) d = -d;
        t = (num * 16384) / d;
        if (best < 0 || t < best_t) begin
          best = a;
          best_t = t;
        end
      end
    end
    if (best < 0 || best_t > longint'(reach)) begin
      walking = 1'b0;
      r = '{KIND_NOTHING, '0, '0, '0};
    end else begin
      cur_vox[best] += (ray_dir[best] > 0) ? 1 : -1;
      r = '{KIND_QUERY, cur_vox[0][15:0], cur_vox[1][15:0], cur_vox[2][15:0]};
    end
    return r;
  endfunction

  // Works out the result of one accepted item and queues it.
  function automatic void predict_walk(ray_item_t it);
    walk_res_t r;
    if (it.operation == OP_START) begin
      ray_org[0] = it.org_x;
      ray_org[1] = it.org_y;
      ray_org[2] = it.org_z;
      ray_dir[0] = it.dir_x;
      ray_dir[1] = it.dir_y;
      ray_dir[2] = it.dir_z;
      cur_vox[0] = longint'($signed(it.org_x[23:8]));
      cur_vox[1] = longint'($signed(it.org_y[23:8]));
      cur_vox[2] = longint'($signed(it.org_z[23:8]));
      empty_vox = cur_vox;
      empty_mode = it.find_empty;
      walking = 1'b1;
      expected_walk.push_back(next_crossing());
    end else if (walking) begin
      if (it.solid) begin
        walking = 1'b0;
        if (empty_mode)
          r = '{KIND_HIT, empty_vox[0][15:0], empty_vox[1][15:0], empty_vox[2][15:0]};
        else
          r = '{KIND_HIT, cur_vox[0][15:0], cur_vox[1][15:0], cur_vox[2][15:0]};
        expected_walk.push_back(r);
      end else begin
        empty_vox = cur_vox;
        expected_walk.push_back(next_crossing());
      end
    end
  endfunction

  // Offers one item, with random idle cycles first, until it is accepted.
  task automatic send_item(ray_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.operation   <= it.operation;
    req.origin_x    <= it.org_x;
    req.origin_y    <= it.org_y;
    req.origin_z    <= it.org_z;
    req.dir_x       <= it.dir_x;
    req.dir_y       <= it.dir_y;
    req.dir_z       <= it.dir_z;
    req.find_empty  <= it.find_empty;
    req.voxel_solid <= it.solid;
    do @(posedge clk_i); while (!req.ready);
    predict_walk(it);
    item_count++;
  endtask

  task automatic send_start(int ox, int oy, int oz, int dx, int dy, int dz, bit fe);
    ray_item_t it;
    it = ray_item_t'($urandom());
    it.operation = OP_START;
    it.org_x = PosW'(ox);
    it.org_y = PosW'(oy);
    it.org_z = PosW'(oz);
    it.dir_x = DirW'(dx);
    it.dir_y = DirW'(dy);
    it.dir_z = DirW'(dz);
    it.find_empty = fe;
    it.solid = 1'($urandom_range(1));
    send_item(it);
  endtask

  // Answer items carry random junk in the ray fields, which must be ignored.
  task automatic send_answer(bit solid);
    ray_item_t it;
    it = ray_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.operation = OP_ANSWER;
    it.solid = solid;
    send_item(it);
  endtask

  // Waits until every expected result has come, then for the block to settle.
  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (expected_walk.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_reach(logic [DistW-1:0] value);
    drain();
    reach_we  <= 1'b1;
    reach_val <= value;
    @(negedge clk_i);
    reach_we  <= 1'b0;
    reach = value;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    walk_res_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_walk.size() == 0) begin
        $error("result with no item waiting: kind %0d", res.kind);
        fail_count++;
      end else begin
        e = expected_walk.pop_front();
        result_count++;
        if (e.kind == KIND_HIT) hit_count++;
        if (e.kind == KIND_NOTHING) nothing_count++;
        if (res.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, res.kind);
          fail_count++;
        end
        if (res.voxel_x !== e.vx) begin
          $error("voxel_x: expected %0d, got %0d", $signed(e.vx), res.voxel_x);
          fail_count++;
        end
        if (res.voxel_y !== e.vy) begin
          $error("voxel_y: expected %0d, got %0d", $signed(e.vy), res.voxel_y);
          fail_count++;
        end
        if (res.voxel_z !== e.vz) begin
          $error("voxel_z: expected %0d, got %0d", $signed(e.vz), res.voxel_z);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Extremes of origin and direction, including coordinate wrap.
  task automatic test_extremes();
    send_start(24'sh7FFF80, -24'sh800000, 0, 16384, 0, 0, 1'b0);
    send_answer(1'b0);
    send_answer(1'b1);
    send_start(-24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 0, -16384, 16384, 1'b1);
    send_answer(1'b0);
    send_answer(1'b0);
    send_answer(1'b1);
  endtask

  // All-zero direction ends at once; a zero axis is never chosen.
  task automatic test_zero_dirs();
    send_start(128, 128, 128, 0, 0, 0, 1'b0);
    send_start(128, 128, 128, 0, 0, -16384, 1'b0);
    send_answer(1'b1);
  endtask

  // Origin on a face with negative direction, and ties between axes.
  task automatic test_faces_ties();
    send_start(3 * 256, 128, 0, -16384, 0, 0, 1'b0);
    send_answer(1'b1);
    send_start(128, 128, 128, 9459, 9459, 9459, 1'b0);
    send_answer(1'b0);
    send_answer(1'b0);
    send_answer(1'b1);
  endtask

  // Answer while idle is dropped; a start while walking drops the old walk.
  task automatic test_idle_restart();
    send_answer(1'b1);
    send_answer(1'b0);
    send_start(0, 0, 0, 11585, -11585, 0, 1'b1);
    send_answer(1'b0);
    send_start(-300, 700, 20, -8000, 6000, 12000, 1'b1);
    send_answer(1'b0);
    send_answer(1'b1);
  endtask

  // Reach extremes: zero ends most walks at once; the largest is set for the walks that follow.
  task automatic test_reach_extremes();
    set_reach(16'd0);
    send_start(128, 128, 128, 16384, 0, 0, 1'b0);
    send_start(256, 0, 0, -16384, 0, 0, 1'b0);
    send_answer(1'b0);
    set_reach(16'hFFFF);
  endtask

  function automatic int rand_dir();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 16384;
      2:       return -16384;
      default: return $urandom_range(32768) - 16384;
    endcase
  endfunction

  function automatic int rand_origin();
    if ($urandom_range(9) == 0)
      return $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
    return $urandom_range(8192) - 4096;
  endfunction

  // Random walks: mostly full walks with random answers, some noise.
  task automatic test_random_walks(int items, int idle, int stall, bit pressure);
    int sent;
    int solid_pct;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    if (pressure) hold_left = HoldCycles;
    while (sent < items) begin
      if ($urandom_range(19) == 0) begin
        send_answer(1'($urandom_range(1)));
      end else begin
        send_start(rand_origin(), rand_origin(), rand_origin(),
                   rand_dir(), rand_dir(), rand_dir(), 1'($urandom_range(1)));
        solid_pct = $urandom_range(5, 40);
        while (walking && sent < items && $urandom_range(49) != 0) begin
          send_answer($urandom_range(99) < solid_pct);
          sent++;
        end
      end
      sent++;
    end
  endtask

  // Safety limit.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    reach_we = 1'b0;
    reach_val = '0;
    req.valid = 1'b0;
    req.operation = OP_START;
    req.origin_x = '0;
    req.origin_y = '0;
    req.origin_z = '0;
    req.dir_x = '0;
    req.dir_y = '0;
    req.dir_z = '0;
    req.find_empty = 1'b0;
    req.voxel_solid = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    fail_count = 0;
    item_count = 0;
    result_count = 0;
    hit_count = 0;
    nothing_count = 0;
    reach = REACH_RESET;
    walking = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_zero_dirs();
    test_faces_ties();
    test_idle_restart();
    test_reach_extremes();

    test_random_walks(240, 20, 71, 1'b1);
    set_reach(16'd1280);
    test_random_walks(240, 71, 20, 1'b0);
    set_reach(16'($urandom_range(256, 4000)));
    test_random_walks(240, 0, 0, 1'b1);
    drain();

    $display("Sent %0d items over directed and random walks at several reach limits.",
             item_count);
    $display("Checked %0d results: %0d hits, %0d out of reach.",
             result_count, hit_count, nothing_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
